// ----- sv/mips_pkg.sv -----
`default_nettype none
package mips_pkg;

    localparam int MAX_RTT_SAMPLES = 1024;
    localparam int SAMPLE_IDX_W = $clog2(MAX_RTT_SAMPLES);
    localparam int SAMPLE_CNT_W = $clog2(MAX_RTT_SAMPLES + 1);
    localparam int RTT_SUM_W = 24 + SAMPLE_IDX_W + 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_W = 72;

    typedef enum logic [1:0] {
        CMD_SENT   = 2'd0,
        CMD_ACKED  = 2'd1,
        CMD_LOST   = 2'd2,
        CMD_REPORT = 2'd3
    } cmd_t;

    localparam logic [0:0] REG_INTERVAL_END = 1'b0;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] now_time;
        logic [30:0] pkt_number;
        logic [15:0] pkt_bytes;
        logic [23:0] rtt_sample;
        logic        all_sent;
    } item_t;

    typedef struct packed {
        logic        all_sent;
        logic        all_accounted;
        logic [31:0] sent_count;
        logic [31:0] accounted_count;
        logic [47:0] throughput;
        logic [47:0] send_rate;
        logic [31:0] mean_rtt;
        logic [18:0] rtt_drift;
        logic [16:0] loss_rate;
        logic        samples_overflow;
    } result_t;

endpackage
`default_nettype wire

// ----- sv/mips_front.sv -----
`default_nettype none
module mips_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [1:0]      cmd,
    input  wire logic [31:0]     now_time,
    input  wire logic [30:0]     pkt_number,
    input  wire logic [15:0]     pkt_bytes,
    input  wire logic [23:0]     rtt_sample,
    input  wire logic [31:0]     interval_end_time,
    output logic                 q_valid,
    output mips_pkg::item_t      q_item,
    input  wire logic            q_pop
);
    mips_pkg::item_t mem_reg [mips_pkg::QUEUE_DEPTH];
    logic [0:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push;

    assign in_stall = (cnt_reg == 2'(mips_pkg::QUEUE_DEPTH));
    assign push = in_valid && !in_stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? wp_reg + 1'b1 : wp_reg;
        rp_next = q_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= '{cmd: mips_pkg::cmd_t'(cmd), now_time: now_time,
                pkt_number: pkt_number, pkt_bytes: pkt_bytes,
                rtt_sample: rtt_sample, all_sent: (now_time >= interval_end_time)};
        end
    end
endmodule
`default_nettype wire

// ----- sv/mips_div.sv -----
`default_nettype none
module mips_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [mips_pkg::DIV_W-1:0]  dividend,
    input  wire logic [47:0]                 divisor,
    output logic                             done,
    output logic [mips_pkg::DIV_W-1:0]       quotient
);
    logic [mips_pkg::DIV_W-1:0] q_reg;
    logic [48:0] r_reg;
    logic [47:0] d_reg;
    logic [6:0] cnt_reg;
    logic busy_reg;
    logic [48:0] r_sh;
    logic ge;

    assign r_sh = {r_reg[47:0], q_reg[mips_pkg::DIV_W-1]};
    assign ge = (r_sh >= {1'b0, d_reg});
    assign done = busy_reg && (cnt_reg == 7'd0);
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 7'(mips_pkg::DIV_W);
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 7'd0)
        begin
            r_reg <= ge ? r_sh - {1'b0, d_reg} : r_sh;
            q_reg <= {q_reg[mips_pkg::DIV_W-2:0], ge};
        end
    end
endmodule
`default_nettype wire

// ----- sv/mips_back.sv -----
`default_nettype none
module mips_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire mips_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 res_valid,
    output mips_pkg::result_t    res,
    input  wire logic            res_take
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_MEAN  = 7'b0000100,
        ST_INFL  = 7'b0001000,
        ST_THR   = 7'b0010000,
        ST_SRATE = 7'b0100000,
        ST_LOSS  = 7'b1000000
    } state_t;

    localparam int IW = mips_pkg::SAMPLE_IDX_W;
    localparam int CW = mips_pkg::SAMPLE_CNT_W;
    localparam int SW = mips_pkg::RTT_SUM_W;

    state_t state_reg, state_next;
    logic [30:0] first_num_reg, last_num_reg;
    logic [31:0] last_acc_reg;
    logic [31:0] first_t_reg, last_t_reg;
    logic [31:0] sent_reg, acc_reg;
    logic [47:0] bsent_reg, backed_reg, blost_reg;
    logic [CW-1:0] scnt_reg;
    logic ovf_reg;
    logic [SW-1:0] last_sum_reg;
    logic [SW-1:0] sums_mem [mips_pkg::MAX_RTT_SAMPLES];
    logic [SW-1:0] rd_a_reg, rd_b_reg;
    logic [IW-1:0] ra_idx, rb_idx, rc_idx;
    logic out_valid_reg;
    mips_pkg::result_t out_reg;
    logic [1:0] cmd_q;
    logic signed [32:0] pkt_s, la_s;
    logic in_range, newly;
    logic [32:0] acc_sum;
    logic [31:0] acc_add;
    logic [SW-1:0] s1, s2, tot, dif;
    logic neg_reg;
    logic div_start, div_done;
    logic [mips_pkg::DIV_W-1:0] div_a, div_q;
    logic [47:0] div_b;
    logic [31:0] dur;
    logic [CW-1:0] half;

    assign cmd_q = q_item.cmd;
    assign pkt_s = {2'b00, q_item.pkt_number};
    assign la_s = {last_acc_reg[31], last_acc_reg};
    assign in_range = (q_item.pkt_number >= first_num_reg) &&
        (q_item.pkt_number <= last_num_reg) && (pkt_s > la_s);
    assign acc_add = 32'(pkt_s - la_s);
    assign acc_sum = {1'b0, acc_reg} + {1'b0, acc_add};
    assign dur = last_t_reg - first_t_reg;
    assign half = scnt_reg >> 1;
    assign res_valid = out_valid_reg;
    assign res = out_reg;

    logic can_out;
    assign can_out = !out_valid_reg || res_take;
    assign q_pop = (state_reg == ST_IDLE) && q_valid && can_out && cmd_q != mips_pkg::CMD_REPORT
        || (state_reg == ST_LOSS) && div_done && can_out;

    assign ra_idx = IW'(scnt_reg - CW'(1));
    assign rb_idx = IW'(half - CW'(1));
    assign rc_idx = IW'((half << 1) - CW'(1));
    assign s1 = rd_b_reg;
    assign s2 = rd_a_reg - rd_b_reg;
    assign tot = s1 + s2;
    assign dif = (s2 >= s1) ? s2 - s1 : s1 - s2;

    always_comb
    begin
        state_next = state_reg;
        div_start = 1'b0;
        div_a = '0;
        div_b = '0;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && cmd_q == mips_pkg::CMD_REPORT && can_out)
                    state_next = ST_RD;
            ST_RD:
            begin
                div_start = 1'b1;
                div_a = mips_pkg::DIV_W'(rd_a_reg) << 8;
                div_b = 48'(scnt_reg);
                state_next = ST_MEAN;
            end
            ST_MEAN:
                if (div_done)
                begin
                    div_start = 1'b1;
                    div_a = mips_pkg::DIV_W'(dif) << 17;
                    div_b = 48'(tot);
                    state_next = ST_INFL;
                end
            ST_INFL:
                if (div_done)
                begin
                    div_start = 1'b1;
                    div_a = mips_pkg::DIV_W'(backed_reg) << 16;
                    div_b = 48'(dur);
                    state_next = ST_THR;
                end
            ST_THR:
                if (div_done)
                begin
                    div_start = 1'b1;
                    div_a = mips_pkg::DIV_W'(bsent_reg) << 16;
                    div_b = 48'(dur);
                    state_next = ST_SRATE;
                end
            ST_SRATE:
                if (div_done)
                begin
                    div_start = 1'b1;
                    div_a = mips_pkg::DIV_W'(backed_reg) << 16;
                    div_b = bsent_reg;
                    state_next = ST_LOSS;
                end
            ST_LOSS:
                if (div_done && can_out)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    mips_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            rd_a_reg <= sums_mem[ra_idx];
            rd_b_reg <= sums_mem[rb_idx];
        end
        else if (state_reg == ST_MEAN)
            rd_a_reg <= sums_mem[rc_idx];
        if (state_reg == ST_IDLE && q_pop && cmd_q == mips_pkg::CMD_ACKED && newly &&
            scnt_reg < CW'(mips_pkg::MAX_RTT_SAMPLES))
            sums_mem[scnt_reg[IW-1:0]] <= last_sum_reg + SW'(q_item.rtt_sample);
    end

    assign newly = in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            first_num_reg <= '0;
            last_num_reg <= '0;
            last_acc_reg <= '0;
            first_t_reg <= '0;
            last_t_reg <= '0;
            sent_reg <= '0;
            acc_reg <= '0;
            bsent_reg <= '0;
            backed_reg <= '0;
            blost_reg <= '0;
            scnt_reg <= '0;
            ovf_reg <= 1'b0;
            last_sum_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (res_take)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_MEAN && div_done)
            begin
                out_reg.mean_rtt <= (scnt_reg == '0) ? '0 : div_q[31:0];
                neg_reg <= s1 > s2;
            end
            if (state_reg == ST_INFL && div_done)
                out_reg.rtt_drift <= (scnt_reg < CW'(2) || tot == '0) ? '0 :
                    (neg_reg ? 19'(-div_q[18:0]) : div_q[18:0]);
            if (state_reg == ST_THR && div_done)
                out_reg.throughput <= (dur == '0) ? '0 :
                    ((|div_q[71:48]) ? '1 : div_q[47:0]);
            if (state_reg == ST_SRATE && div_done)
                out_reg.send_rate <= (dur == '0) ? '0 :
                    ((|div_q[71:48]) ? '1 : div_q[47:0]);
            if (state_reg == ST_LOSS && div_done && can_out)
            begin
                out_reg.loss_rate <= (bsent_reg == '0 || div_q >= 72'd65536) ? '0 :
                    17'(17'd65536 - 17'(div_q));
                out_reg.all_sent <= q_item.all_sent;
                out_reg.all_accounted <= acc_reg == sent_reg;
                out_reg.sent_count <= sent_reg;
                out_reg.accounted_count <= acc_reg;
                out_reg.samples_overflow <= ovf_reg;
            end
            if (state_reg == ST_IDLE && q_pop)
            begin
                logic [31:0] s_new, a_new;
                logic [48:0] badd;
                s_new = sent_reg;
                a_new = acc_reg;
                badd = '0;
                unique case (cmd_q)
                    mips_pkg::CMD_SENT:
                    begin
                        if (sent_reg == '0)
                        begin
                            first_t_reg <= q_item.now_time;
                            first_num_reg <= q_item.pkt_number;
                            last_acc_reg <= {1'b0, q_item.pkt_number} - 32'd1;
                        end
                        last_t_reg <= q_item.now_time;
                        last_num_reg <= q_item.pkt_number;
                        if (sent_reg != '1)
                            s_new = sent_reg + 32'd1;
                        badd = {1'b0, bsent_reg} + 49'(q_item.pkt_bytes);
                        bsent_reg <= badd[48] ? '1 : badd[47:0];
                    end
                    mips_pkg::CMD_ACKED, mips_pkg::CMD_LOST:
                    begin
                        if (in_range)
                        begin
                            a_new = acc_sum[32] ? '1 : acc_sum[31:0];
                            last_acc_reg <= {1'b0, q_item.pkt_number};
                            if (cmd_q == mips_pkg::CMD_ACKED)
                            begin
                                badd = {1'b0, backed_reg} + 49'(q_item.pkt_bytes);
                                backed_reg <= badd[48] ? '1 : badd[47:0];
                                if (scnt_reg < CW'(mips_pkg::MAX_RTT_SAMPLES))
                                begin
                                    scnt_reg <= scnt_reg + CW'(1);
                                    last_sum_reg <= last_sum_reg + SW'(q_item.rtt_sample);
                                end
                                else
                                    ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                badd = {1'b0, blost_reg} + 49'(q_item.pkt_bytes);
                                blost_reg <= badd[48] ? '1 : badd[47:0];
                            end
                        end
                        else if (q_item.pkt_number > last_num_reg)
                            a_new = sent_reg;
                    end
                    default: ;
                endcase
                sent_reg <= s_new;
                acc_reg <= a_new;
                out_reg <= '{all_sent: q_item.all_sent, all_accounted: a_new == s_new,
                    sent_count: s_new, accounted_count: a_new, throughput: '0,
                    send_rate: '0, mean_rtt: '0, rtt_drift: '0, loss_rate: '0,
                    samples_overflow: ovf_reg || (cmd_q == mips_pkg::CMD_ACKED &&
                    in_range && scnt_reg >= CW'(mips_pkg::MAX_RTT_SAMPLES))};
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/monitor_interval_packet_stats_core.sv -----
// Monitor-interval statistics. Sent, acked and lost beats update counters; a
// report beat runs five 72-step serial divisions before its result appears. A
// two-entry queue decouples input from the update engine; the output register
// holds one result beat.
`default_nettype none
module monitor_interval_packet_stats_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [31:0] now_time,
    input  wire logic [30:0] pkt_number,
    input  wire logic [15:0] pkt_bytes,
    input  wire logic [23:0] rtt_sample,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             all_sent,
    output logic             all_accounted,
    output logic [31:0]      sent_count,
    output logic [31:0]      accounted_count,
    output logic [47:0]      throughput,
    output logic [47:0]      send_rate,
    output logic [31:0]      mean_rtt,
    output logic [18:0]      rtt_drift,
    output logic [16:0]      loss_rate,
    output logic             samples_overflow
);
    logic [31:0] win_end_reg;
    logic q_valid, q_pop;
    mips_pkg::item_t q_item;
    mips_pkg::result_t res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == mips_pkg::REG_INTERVAL_END) ? win_end_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_end_reg <= '0;
        else if (psel && penable && pwrite && paddr[2] == mips_pkg::REG_INTERVAL_END)
            win_end_reg <= pwdata;
    end

    mips_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .now_time(now_time), .pkt_number(pkt_number),
        .pkt_bytes(pkt_bytes), .rtt_sample(rtt_sample),
        .interval_end_time(win_end_reg), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop)
    );

    mips_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .res_valid(out_valid), .res(res), .res_take(!out_stall)
    );

    assign all_sent = res.all_sent;
    assign all_accounted = res.all_accounted;
    assign sent_count = res.sent_count;
    assign accounted_count = res.accounted_count;
    assign throughput = res.throughput;
    assign send_rate = res.send_rate;
    assign mean_rtt = res.mean_rtt;
    assign rtt_drift = res.rtt_drift;
    assign loss_rate = res.loss_rate;
    assign samples_overflow = res.samples_overflow;
endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint LIMIT = 3000000;

    class stats_scoreboard;
        logic [31:0] win_end;
        logic [30:0] first_num;
        logic [30:0] last_num;
        logic [31:0] last_acc;
        logic [31:0] first_t;
        logic [31:0] last_t;
        logic [31:0] n_sent;
        logic [31:0] n_acc;
        logic [47:0] b_sent;
        logic [47:0] b_acked;
        logic [47:0] b_lost;
        logic [63:0] prefix [mips_pkg::MAX_RTT_SAMPLES];
        int unsigned n_samples;
        bit          ovf;
        mips_pkg::result_t pending [$];
        int          errors;
        int          n_reports;

        function new();
            win_end = 0;
            first_num = 0;
            last_num = 0;
            last_acc = 0;
            first_t = 0;
            last_t = 0;
            n_sent = 0;
            n_acc = 0;
            b_sent = 0;
            b_acked = 0;
            b_lost = 0;
            n_samples = 0;
            ovf = 0;
            errors = 0;
            n_reports = 0;
        endfunction

        function logic [47:0] add48(logic [47:0] a, logic [15:0] b);
            logic [48:0] s;
            s = {1'b0, a} + b;
            return s[48] ? '1 : s[47:0];
        endfunction

        function logic [47:0] rate16(logic [47:0] bytes, logic [31:0] dur);
            logic [63:0] q;
            if (dur == 0)
                return 0;
            q = {bytes, 16'h0} / dur;
            return (q > 64'hFFFF_FFFF_FFFF) ? '1 : q[47:0];
        endfunction

        function bit account(logic [30:0] pkt);
            longint la;
            longint p;
            longint unsigned n;
            la = longint'($signed(last_acc));
            p = longint'(pkt);
            if (pkt >= first_num && pkt <= last_num && p > la)
            begin
                n = longint'(n_acc) + (p - la);
                n_acc = (n > 64'hFFFF_FFFF) ? '1 : n[31:0];
                last_acc = {1'b0, pkt};
                return 1;
            end
            if (pkt > last_num)
                n_acc = n_sent;
            return 0;
        endfunction

        function void note(mips_pkg::cmd_t c, logic [31:0] now, logic [30:0] pkt,
                           logic [15:0] bytes, logic [23:0] rtt);
            mips_pkg::result_t r;
            logic [31:0] dur;
            logic [63:0] s1, s2, tot, q;
            logic [63:0] prev;
            int unsigned half;
            r = '0;
            unique case (c)
                mips_pkg::CMD_SENT:
                begin
                    if (n_sent == 0)
                    begin
                        first_t = now;
                        first_num = pkt;
                        last_acc = {1'b0, pkt} - 32'd1;
                    end
                    last_t = now;
                    last_num = pkt;
                    if (n_sent != 32'hFFFF_FFFF)
                        n_sent++;
                    b_sent = add48(b_sent, bytes);
                end
                mips_pkg::CMD_ACKED:
                begin
                    if (account(pkt))
                    begin
                        b_acked = add48(b_acked, bytes);
                        if (n_samples < mips_pkg::MAX_RTT_SAMPLES)
                        begin
                            prev = n_samples ? prefix[n_samples - 1] : 64'd0;
                            prefix[n_samples] = prev + rtt;
                            n_samples++;
                        end
                        else
                            ovf = 1;
                    end
                end
                mips_pkg::CMD_LOST:
                begin
                    if (account(pkt))
                        b_lost = add48(b_lost, bytes);
                end
                default:
                begin
                    n_reports++;
                    dur = last_t - first_t;
                    r.throughput = rate16(b_acked, dur);
                    r.send_rate = rate16(b_sent, dur);
                    if (n_samples > 0)
                    begin
                        q = (prefix[n_samples - 1] << 8) / n_samples;
                        r.mean_rtt = q[31:0];
                    end
                    if (n_samples >= 2)
                    begin
                        half = n_samples / 2;
                        s1 = prefix[half - 1];
                        s2 = prefix[2 * half - 1] - s1;
                        tot = s1 + s2;
                        if (tot != 0)
                        begin
                            if (s2 >= s1)
                            begin
                                q = ((s2 - s1) << 17) / tot;
                                r.rtt_drift = q[18:0];
                            end
                            else
                            begin
                                q = ((s1 - s2) << 17) / tot;
                                q = 64'd0 - q;
                                r.rtt_drift = q[18:0];
                            end
                        end
                    end
                    if (b_sent != 0)
                    begin
                        q = {b_acked, 16'h0} / b_sent;
                        r.loss_rate = (q >= 65536) ? 17'd0 : 17'(65536 - q);
                    end
                end
            endcase
            r.all_sent = (now >= win_end);
            r.all_accounted = (n_acc == n_sent);
            r.sent_count = n_sent;
            r.accounted_count = n_acc;
            r.samples_overflow = ovf;
            pending.insert(pending.size(), r);
        endfunction

        function void cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                $error("%s: expected %0h, got %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check(mips_pkg::result_t got);
            mips_pkg::result_t e;
            if (pending.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("all_sent", e.all_sent, got.all_sent);
            cmp("all_accounted", e.all_accounted, got.all_accounted);
            cmp("sent_count", e.sent_count, got.sent_count);
            cmp("accounted_count", e.accounted_count, got.accounted_count);
            cmp("throughput", e.throughput, got.throughput);
            cmp("send_rate", e.send_rate, got.send_rate);
            cmp("mean_rtt", e.mean_rtt, got.mean_rtt);
            cmp("rtt_drift", e.rtt_drift, got.rtt_drift);
            cmp("loss_rate", e.loss_rate, got.loss_rate);
            cmp("samples_overflow", e.samples_overflow, got.samples_overflow);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [31:0] now_time;
    logic [30:0] pkt_number;
    logic [15:0] pkt_bytes;
    logic [23:0] rtt_sample;
    logic        out_valid;
    logic        out_stall;
    mips_pkg::result_t got;

    stats_scoreboard sb;
    bit          quiet;
    longint      cycles = 0;
    logic [30:0] next_pkt;
    logic [31:0] tnow;
    int          n_items;

    monitor_interval_packet_stats_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .now_time         (now_time),
        .pkt_number       (pkt_number),
        .pkt_bytes        (pkt_bytes),
        .rtt_sample       (rtt_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .all_sent         (got.all_sent),
        .all_accounted    (got.all_accounted),
        .sent_count       (got.sent_count),
        .accounted_count  (got.accounted_count),
        .throughput       (got.throughput),
        .send_rate        (got.send_rate),
        .mean_rtt         (got.mean_rtt),
        .rtt_drift        (got.rtt_drift),
        .loss_rate        (got.loss_rate),
        .samples_overflow (got.samples_overflow)
    );

    initial clk = 0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function int draw_gap();
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic push(mips_pkg::cmd_t c, logic [31:0] now, logic [30:0] pkt,
                        logic [15:0] bytes, logic [23:0] rtt);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        now_time <= now;
        pkt_number <= pkt;
        pkt_bytes <= bytes;
        rtt_sample <= rtt;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note(c, now, pkt, bytes, rtt);
        n_items++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == 3'd0)
            sb.win_end = value;
        @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int k;
        int sel;
        logic [30:0] pkt;
        logic [30:0] lo;
        for (k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            tnow = tnow + $urandom_range(0, 3000);
            if (sel < 35)
            begin
                push(mips_pkg::CMD_SENT, tnow, next_pkt, 16'($urandom), 24'($urandom));
                next_pkt = next_pkt + 1;
            end
            else if (sel < 80)
            begin
                lo = sb.last_acc[30:0] + 31'd1;
                if ($urandom_range(0, 3) == 0)
                    pkt = sb.first_num + 31'($urandom_range(0, next_pkt - sb.first_num));
                else
                    pkt = lo + 31'($urandom_range(0, 2));
                if (sel < 70)
                    push(mips_pkg::CMD_ACKED, tnow, pkt, 16'($urandom), 24'($urandom));
                else
                    push(mips_pkg::CMD_LOST, tnow, pkt, 16'($urandom), 24'($urandom));
            end
            else if (sel < 88)
                push(mips_pkg::CMD_REPORT, tnow, 31'($urandom), 16'($urandom),
                     24'($urandom));
            else
                push(mips_pkg::cmd_t'($urandom_range(0, 3)), $urandom, 31'($urandom),
                     16'($urandom), 24'($urandom));
        end
    endtask

    initial
    begin
        out_stall <= 0;
        @(posedge rst_n);
        forever
        begin
            int n;
            n = draw_gap();
            if (n > 0)
            begin
                out_stall <= 1;
                repeat (n) @(posedge clk);
                out_stall <= 0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check(got);
        end
    end

    initial
    begin
        int p;
        sb = new();
        n_items = 0;
        quiet = 0;
        rst_n <= 0;
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        paddr <= 0;
        pwdata <= 0;
        in_valid <= 0;
        cmd <= mips_pkg::CMD_SENT;
        now_time <= 0;
        pkt_number <= 0;
        pkt_bytes <= 0;
        rtt_sample <= 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        reg_write(3'd0, 32'd0);
        reg_write(3'd4, 32'hFFFF_FFFF);
        push(mips_pkg::CMD_REPORT, 32'd0, 31'd0, 16'd0, 24'd0);
        push(mips_pkg::CMD_ACKED, 32'd0, 31'd0, 16'd9, 24'd9);
        push(mips_pkg::CMD_SENT, 32'd0, 31'd0, 16'd0, 24'd0);
        push(mips_pkg::CMD_REPORT, 32'd0, 31'd0, 16'd0, 24'd0);
        push(mips_pkg::CMD_SENT, 32'd100, 31'd1, 16'hFFFF, 24'd0);
        push(mips_pkg::CMD_ACKED, 32'd110, 31'd0, 16'hFFFF, 24'hFF_FFFF);
        push(mips_pkg::CMD_ACKED, 32'd111, 31'd0, 16'hFFFF, 24'd5);
        push(mips_pkg::CMD_LOST, 32'd120, 31'd1, 16'd10, 24'd0);
        push(mips_pkg::CMD_REPORT, 32'd130, 31'd0, 16'd0, 24'd0);
        push(mips_pkg::CMD_SENT, 32'd50, 31'd2, 16'd1500, 24'd0);
        push(mips_pkg::CMD_SENT, 32'hFFFF_FFFF, 31'd3, 16'd1, 24'd0);
        push(mips_pkg::CMD_ACKED, 32'd200, 31'd3, 16'd1, 24'd0);
        push(mips_pkg::CMD_ACKED, 32'd201, 31'd2, 16'd7, 24'd7);
        push(mips_pkg::CMD_REPORT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
        push(mips_pkg::CMD_SENT, 32'd300, 31'd4, 16'd40, 24'd0);
        push(mips_pkg::CMD_ACKED, 32'd301, 31'h7FFF_FFFF, 16'd40, 24'd3);
        push(mips_pkg::CMD_LOST, 32'd302, 31'h7FFF_FFFF, 16'd40, 24'd3);
        push(mips_pkg::CMD_SENT, 32'd5, 31'd5, 16'd40, 24'd0);
        push(mips_pkg::CMD_ACKED, 32'd6, 31'd5, 16'd40, 24'd100);
        push(mips_pkg::CMD_REPORT, 32'd7, 31'd0, 16'd0, 24'd0);
        drain();

        next_pkt = 31'd6;
        tnow = 32'd1000;
        for (p = 0; p < 4; p++)
        begin
            unique case (p)
                0: reg_write(3'd0, 32'hFFFF_FFFF);
                1: reg_write(3'd0, $urandom);
                2: reg_write(3'd0, 32'h8000_0000);
                default: reg_write(3'd0, 32'd0);
            endcase
            quiet = (p == 2);
            random_phase(240);
            push(mips_pkg::CMD_REPORT, tnow, 31'd0, 16'd0, 24'd0);
            drain();
        end
        quiet = 0;
        repeat (400) @(posedge clk);

        $display("Ran %0d beats with %0d reports over %0d cycles;", n_items, sb.n_reports,
                 cycles);
        $display("sample store filled to %0d with overflow flag %0b.", sb.n_samples, sb.ovf);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
sv/mips_pkg.sv
sv/mips_front.sv
sv/mips_div.sv
sv/mips_back.sv
sv/monitor_interval_packet_stats_core.sv
test/tb.sv
